[src/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// Set-associative cache LRU lookup: shared definitions
// Widths of the stream fields and the layout of one result item.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned WAY_OUT_W   = 2;
  localparam int unsigned M_TDATA_W   = 8;
  localparam int unsigned RES_W       = WAY_OUT_W + 1;

  // One result item, hit in the lowest bit.
  typedef struct packed {
    logic [WAY_OUT_W-1:0] way_used;
    logic                 hit;
  } res_t;

endpackage

[src/set_assoc_cache_lru_lookup.sv]
// ----------------------------------------------------------------------------
// Set-associative cache LRU lookup
// Hit/miss decision of a set-associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// Each address item on the slave stream is looked up in set address mod
// NUM_SETS; the whole address is the tag. A hit makes the matching way most
// recently used, a miss loads the least recently used way. One result item
// per address leaves on the master stream, in order.
// The front end computes the set index and feeds a two-entry queue; the back
// end does a read-modify-write of the set row, reading it on pop and writing
// it back when the result is registered, and takes no new item until then.
// When NUM_SETS is not a power of two the remainder unit works each address
// through its multiply, quotient and remainder steps before taking the next.
// After reset a clearing pass over all NUM_SETS rows empties the valid bits and
// restores the recency order; no item is accepted during it.
// A stalled result holds in the output register; the queue keeps taking
// items until it is full, then tready falls.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned WAYS     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]    s_axis_tdata,   // [31:0] address
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sacl_pkg::M_TDATA_W-1:0] m_axis_tdata    // [0] hit, [2:1] way_used
);

  localparam int unsigned SB = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AW = sacl_pkg::ADDR_W;
  localparam int unsigned DW = AW + SB;

  logic           init_done;
  logic           f_valid, f_ready, q_valid, q_ready;
  logic [AW-1:0]  f_addr;
  logic [SB-1:0]  f_set;
  logic [DW-1:0]  q_data;
  sacl_pkg::res_t result;

  sacl_front #(
    .NUM_SETS (NUM_SETS),
    .SB       (SB)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (init_done),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid_o  (f_valid),
    .push_ready_i  (f_ready),
    .push_addr_o   (f_addr),
    .push_set_o    (f_set)
  );

  sacl_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_set, f_addr}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  sacl_back #(
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS),
    .SB       (SB),
    .WB       (WB)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .init_done_o   (init_done),
    .pop_valid_i   (q_valid),
    .pop_ready_o   (q_ready),
    .pop_addr_i    (q_data[AW-1:0]),
    .pop_set_i     (q_data[DW-1:AW]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tdata = sacl_pkg::M_TDATA_W'(result);

endmodule

[src/sacl_front.sv]
// ----------------------------------------------------------------------------
// Set-associative cache LRU lookup: front end
// Accepts addresses and works out the set index before handing them on.
// ----------------------------------------------------------------------------
module sacl_front #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned SB       = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sacl_pkg::ADDR_W-1:0] s_axis_tdata,   // [31:0] address
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output logic [sacl_pkg::ADDR_W-1:0] push_addr_o,
  output logic [SB-1:0]               push_set_o
);

  localparam int unsigned AW       = sacl_pkg::ADDR_W;
  localparam bit          POW2     = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam int unsigned LOG_SETS = $clog2(NUM_SETS);
  // Scaled reciprocal of the set count, exact for every 32-bit address. When
  // the count is not a power of two it lies between 2^32 and 2^33, so only
  // the low word is multiplied and the 2^32 part is added back.
  localparam logic [63:0]   RECIP    = ((64'd1 << (AW + LOG_SETS)) + 64'(NUM_SETS) - 64'd1)
                                       / 64'(NUM_SETS);
  localparam logic [AW-1:0] RECIP_LO = RECIP[AW-1:0];
  localparam logic [AW-1:0] SETS_W   = AW'(NUM_SETS);
  localparam logic [AW-1:0] SET_MASK = AW'(NUM_SETS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUO,
    ST_REM
  } state_e;

  state_e          state_q, state_d;
  logic            fv_q, fv_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [2*AW-1:0] prod_q, prod_d;
  logic [AW-1:0]   quo_q, quo_d;
  logic [SB-1:0]   set_q, set_d;
  logic [AW:0]     quo_sum;
  logic [AW-1:0]   rem;
  logic            accept;

  assign s_axis_tready = en_i && (state_q == ST_IDLE) && (!fv_q || push_ready_i);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_valid_o  = fv_q;
  assign push_addr_o   = addr_q;
  assign push_set_o    = set_q;

  // Remainder by reciprocal multiplication: the quotient comes from the high
  // word of the product, the remainder from one multiply-subtract.
  always_comb begin
    quo_sum = {1'b0, addr_q} + {1'b0, prod_q[2*AW-1:AW]};
    rem     = addr_q - quo_q * SETS_W;
  end

  always_comb begin
    state_d = state_q;
    fv_d    = fv_q;
    addr_d  = addr_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    set_d   = set_q;
    if (fv_q && push_ready_i) begin
      fv_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_d = s_axis_tdata;
          if (POW2) begin
            set_d = SB'(s_axis_tdata & SET_MASK);
            fv_d  = 1'b1;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_d  = (2 * AW)'(addr_q) * (2 * AW)'(RECIP_LO);
        state_d = ST_QUO;
      end
      ST_QUO: begin
        quo_d   = AW'(quo_sum >> LOG_SETS);
        state_d = ST_REM;
      end
      ST_REM: begin
        set_d   = rem[SB-1:0];
        fv_d    = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fv_q    <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    set_q  <= set_d;
  end

endmodule

[src/sacl_queue.sv]
// ----------------------------------------------------------------------------
// Set-associative cache LRU lookup: decoupling queue
// Two-entry FIFO between the front end and the lookup back end.
// ----------------------------------------------------------------------------
module sacl_queue #(
  parameter int unsigned DW = 38
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

[src/sacl_back.sv]
// ----------------------------------------------------------------------------
// Set-associative cache LRU lookup: back end
// Reads a set's tags, valid bits and recency order, decides hit or fill,
// writes the set back and presents the result item.
// ----------------------------------------------------------------------------
module sacl_back #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned WAYS     = 4,
  parameter int unsigned SB       = 6,
  parameter int unsigned WB       = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        init_done_o,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  logic [sacl_pkg::ADDR_W-1:0] pop_addr_i,
  input  logic [SB-1:0]               pop_set_i,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output sacl_pkg::res_t              result_o
);

  localparam int unsigned AW = sacl_pkg::ADDR_W;

  typedef logic [WAYS-1:0][WB-1:0] order_t;

  function automatic order_t init_order();
    order_t o;
    for (int i = 0; i < WAYS; i++) begin
      o[i] = WB'(i);
    end
    return o;
  endfunction

  localparam order_t ORDER_INIT = init_order();

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e                 state_q, state_d;
  logic [SB-1:0]          clr_q, clr_d;
  logic [AW-1:0]          cur_addr_q, cur_addr_d;
  logic [SB-1:0]          cur_set_q, cur_set_d;
  logic                   out_v_q, out_v_d;
  sacl_pkg::res_t         res_q, res_d;

  logic [WAYS-1:0][AW-1:0] tag_mem [NUM_SETS];
  logic [WAYS-1:0]         val_mem [NUM_SETS];
  order_t                  ord_mem [NUM_SETS];
  logic [WAYS-1:0][AW-1:0] tag_rd_q;
  logic [WAYS-1:0]         val_rd_q;
  order_t                  ord_rd_q;

  logic                    pop, fire;
  logic                    hit;
  logic [WB-1:0]           hit_way, victim, way, pos;
  order_t                  ord_new;
  logic [WAYS-1:0]         val_new;
  logic [WB+1:0]           way_ext;

  assign init_done_o   = (state_q != ST_CLEAR);
  assign pop_ready_o   = (state_q == ST_IDLE);
  assign pop           = pop_valid_i && pop_ready_o;
  assign fire          = (state_q == ST_LOOK) && (!out_v_q || m_axis_tready);
  assign m_axis_tvalid = out_v_q;
  assign result_o      = res_q;

  // Hit search: the lowest matching valid way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (val_rd_q[w] && (tag_rd_q[w] == cur_addr_q)) begin
        hit     = 1'b1;
        hit_way = WB'(w);
      end
    end
    victim = ord_rd_q[0];
    if ({1'b0, victim} >= (WB + 1)'(WAYS)) begin
      victim = '0;
    end
    way = hit ? hit_way : victim;
  end

  // Move the used way to the most recent end of the order.
  always_comb begin
    pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (ord_rd_q[i] == way) begin
        pos = WB'(i);
      end
    end
    ord_new = ord_rd_q;
    for (int i = 0; i < WAYS - 1; i++) begin
      if (WB'(i) >= pos) begin
        ord_new[i] = ord_rd_q[i + 1];
      end
    end
    ord_new[WAYS-1] = way;
    val_new = val_rd_q;
    for (int w = 0; w < WAYS; w++) begin
      if (WB'(w) == way) begin
        val_new[w] = 1'b1;
      end
    end
    way_ext = (WB + 2)'(way);
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_addr_d = cur_addr_q;
    cur_set_d  = cur_set_q;
    out_v_d    = out_v_q;
    res_d      = res_q;
    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SB'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          cur_addr_d = pop_addr_i;
          cur_set_d  = pop_set_i;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (fire) begin
          out_v_d        = 1'b1;
          res_d.hit      = hit;
          res_d.way_used = way_ext[sacl_pkg::WAY_OUT_W-1:0];
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      cur_addr_q <= '0;
      cur_set_q  <= '0;
      out_v_q    <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      cur_addr_q <= cur_addr_d;
      cur_set_q  <= cur_set_d;
      out_v_q    <= out_v_d;
      res_q      <= res_d;
    end
  end

  // Set memories: one row per set, read on pop, written when the item retires or while clearing.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      tag_rd_q <= tag_mem[pop_set_i];
      val_rd_q <= val_mem[pop_set_i];
      ord_rd_q <= ord_mem[pop_set_i];
    end
    if (state_q == ST_CLEAR) begin
      val_mem[clr_q] <= '0;
      ord_mem[clr_q] <= ORDER_INIT;
    end else if (fire) begin
      val_mem[cur_set_q] <= val_new;
      ord_mem[cur_set_q] <= ord_new;
      if (!hit) begin
        tag_mem[cur_set_q][way] <= cur_addr_q;
      end
    end
  end

endmodule

[src/sacl_checker.sv]
// ----------------------------------------------------------------------------
// Set-associative cache LRU lookup: port checker
// Watches the top level's streams and checks their behaviour over time.
// ----------------------------------------------------------------------------
module sacl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sacl_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result item must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // The clearing pass runs first, so nothing moves right after reset.
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("stream active straight after reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[sacl_pkg::M_TDATA_W-1:sacl_pkg::RES_W] == '0)
    else $error("padding bits of result item not zero");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/sacl_lookup_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lookup checker for the set-associative cache LRU lookup
// Watches both streams, keeps its own copy of the tags, valid bits and
// recency order, and compares each result item with the predicted one.
// ----------------------------------------------------------------------------
module sacl_lookup_checker #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned WAYS     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]    s_axis_tdata,   // [31:0] address
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [sacl_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [0] hit, [2:1] way_used
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    hit_count_o,
  output int unsigned                    miss_count_o
);

  import sacl_pkg::*;

  logic [ADDR_W-1:0] tag_mem   [NUM_SETS][WAYS];
  logic              valid_mem [NUM_SETS][WAYS];
  // Ways of each set, least recently used first.
  int unsigned       lru_order [NUM_SETS][WAYS];
  res_t              predicted_results [$];

  function automatic res_t lookup_address(input logic [ADDR_W-1:0] addr);
    int unsigned set_idx;
    int unsigned way;
    int unsigned pos;
    logic        found;
    res_t        res;
    set_idx = addr % NUM_SETS;
    found   = 1'b0;
    way     = 0;
    pos     = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && valid_mem[set_idx][w] && tag_mem[set_idx][w] == addr) begin
        found = 1'b1;
        way   = w;
      end
    end
    // A miss always takes the least recently used way, empty or not.
    if (!found) begin
      way                     = lru_order[set_idx][0];
      tag_mem[set_idx][way]   = addr;
      valid_mem[set_idx][way] = 1'b1;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (lru_order[set_idx][i] == way) pos = i;
    end
    for (int i = pos; i + 1 < WAYS; i++) begin
      lru_order[set_idx][i] = lru_order[set_idx][i + 1];
    end
    lru_order[set_idx][WAYS-1] = way;
    res.hit      = found;
    res.way_used = way[WAY_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          valid_mem[s][w] = 1'b0;
          lru_order[s][w] = w;
        end
      end
      predicted_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      hit_count_o  = 0;
      miss_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with no lookup outstanding: tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          got  = res_t'(m_axis_tdata[RES_W-1:0]);
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            fail_count_o++;
          end
          if (got.way_used !== want.way_used) begin
            $error("way_used: expected %0d, actual %0d", want.way_used, got.way_used);
            fail_count_o++;
          end
          if (want.hit) hit_count_o++;
          else miss_count_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_results.push_back(lookup_address(s_axis_tdata));
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the set-associative cache LRU lookup
// Sends directed and random addresses, mostly drawn from a few busy sets so
// that hits, fills and evictions all occur, under three pacing phases.
// ----------------------------------------------------------------------------
module testbench;

  import sacl_pkg::*;

  localparam int unsigned NUM_SETS     = 64;
  localparam int unsigned WAYS         = 4;
  localparam int unsigned PHASE_ITEMS  = 610;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned N_DIRECTED   = 20;

  // Fill set 0 and evict from it, then work the top set and all-ones address.
  localparam logic [ADDR_W-1:0] DIRECTED_ADDRS [N_DIRECTED] = '{
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0040, 32'h0000_0080,
    32'h0000_00C0, 32'h0000_0000, 32'h0000_0100, 32'h0000_0040, 32'h0000_00C0,
    32'h0000_0080, 32'hFFFF_FFBF, 32'h7FFF_FFFF, 32'h8000_003F, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ADDR_W-1:0]    s_axis_tdata  = '0;    // [31:0] address
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;          // [0] hit, [2:1] way_used

  int unsigned fail_count;
  int unsigned pending_lookups;
  int unsigned hit_count;
  int unsigned miss_count;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_cycles = 0;

  logic [25:0] hot_tag [6];
  logic [5:0]  hot_set [8];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  set_assoc_cache_lru_lookup #(
    .NUM_SETS(NUM_SETS),
    .WAYS    (WAYS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  sacl_lookup_checker #(
    .NUM_SETS(NUM_SETS),
    .WAYS    (WAYS)
  ) u_lookup_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_lookups),
    .hit_count_o  (hit_count),
    .miss_count_o (miss_count)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Ends the run if neither stream moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Most addresses come from a small pool of tags over a few sets, so that
  // sets fill, hit and evict; the rest are fully random.
  task automatic run_random_phase(input int unsigned n_items);
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < 6; i++) hot_tag[i] = 26'($urandom());
    for (int i = 0; i < 8; i++) hot_set[i] = 6'($urandom_range(0, NUM_SETS - 1));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        addr = {hot_tag[3'($urandom_range(0, 5))], hot_set[3'($urandom_range(0, 7))]};
      end else begin
        addr = $urandom();
      end
      send_address(addr);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 25;
    rx_idle_pct = 70;
    for (int i = 0; i < N_DIRECTED; i++) send_address(DIRECTED_ADDRS[i]);
    run_random_phase(PHASE_ITEMS);

    tx_idle_pct = 70;
    rx_idle_pct = 25;
    run_random_phase(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(PHASE_ITEMS);
    s_axis_tvalid <= 1'b0;

    wait (pending_lookups == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d lookups (%0d hits, %0d misses) over three pacing phases,",
             hit_count + miss_count, hit_count, miss_count);
    $display("including set fills, LRU evictions and the all-ones address.");
    if (fail_count == 0 && pending_lookups == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
src/sacl_pkg.sv
src/sacl_front.sv
src/sacl_queue.sv
src/sacl_back.sv
src/set_assoc_cache_lru_lookup.sv
src/sacl_checker.sv
verif/sacl_lookup_checker.sv
verif/testbench.sv
